// ===== design/pgf_pkg.sv =====
package pgf_pkg;

	// Sector geometry
	localparam int SECTORS     = 36;
	localparam int MAX_RESULTS = 18;
	localparam int SEC_W       = $clog2(SECTORS);
	localparam int CNT_W       = $clog2(SECTORS + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	// Angle arithmetic, 1/16 degree
	localparam int FULL_TURN = 5760;
	localparam int HALF_TURN = 2880;
	localparam int POS_W     = $clog2(FULL_TURN);
	localparam int PROD_W    = $clog2(FULL_TURN * SECTORS);

	// floor(x / FULL_TURN) by reciprocal; estimate is exact or one low
	localparam int RCP_SH = PROD_W + 5;
	localparam int RCP    = (1 << RCP_SH) / FULL_TURN;
	localparam int RCP_W  = $clog2(RCP + 1);

	// Field widths fixed by the interface
	localparam int ANG_W  = 14;
	localparam int DIST_W = 16;
	localparam int DIR_W  = 13;
	localparam int GAP_W  = 6;
	localparam int MASK_W = 3;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_MAX_RANGE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_BLK_LEVEL = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MASK_WID  = 2'd2;

	typedef logic signed [DIR_W-1:0] dir_t;
	typedef dir_t centre_tab_t [SECTORS];

	function automatic centre_tab_t centre_table();
		centre_tab_t t;
		for (int i = 0; i < SECTORS; i++) begin
			t[i] = dir_t'(((2 * i + 1) * HALF_TURN) / SECTORS - HALF_TURN);
		end
		return t;
	endfunction

	localparam centre_tab_t CENTRE = centre_table();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RCP,
		ST_FIX,
		ST_RD,
		ST_WR,
		ST_SWEEP,
		ST_DILATE,
		ST_WALK,
		ST_EMPTY,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic rcp;
		logic fix;
		logic rd;
		logic wr;
		logic sweep;
		logic dilate;
		logic walk;
		logic empty;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic sweep_done;
		logic walk_done;
		logic empty_done;
	} stat_t;

endpackage

// ===== design/pgf_intf.sv =====
interface pgf_pt_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pgf_pkg::ANG_W-1:0]      angle_q;
	logic        [pgf_pkg::DIST_W-1:0]     distance_mm;
	logic                                  scan_end;

	modport source(output valid, angle_q, distance_mm, scan_end, input ready);
	modport sink(input valid, angle_q, distance_mm, scan_end, output ready);
endinterface

interface pgf_gap_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pgf_pkg::DIR_W-1:0]      direction_q;
	logic        [pgf_pkg::GAP_W-1:0]      gap_first;
	logic        [pgf_pkg::GAP_W-1:0]      gap_final;
	logic        [pgf_pkg::SECTORS-1:0]    blocked_map;
	logic                                  has_gap;
	logic                                  final_gap;

	modport source(output valid, direction_q, gap_first, gap_final, blocked_map,
		has_gap, final_gap, input ready);
	modport sink(input valid, direction_q, gap_first, gap_final, blocked_map,
		has_gap, final_gap, output ready);
endinterface

// ===== design/pgf_ctrl.sv =====
module pgf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pgf_pkg::stat_t stat,
	output pgf_pkg::cmd_t  cmd
);

	pgf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgf_pkg::ST_IDLE:   if (in_valid) state_d = pgf_pkg::ST_MUL;
			pgf_pkg::ST_MUL:    state_d = pgf_pkg::ST_RCP;
			pgf_pkg::ST_RCP:    state_d = pgf_pkg::ST_FIX;
			pgf_pkg::ST_FIX:    state_d = pgf_pkg::ST_RD;
			pgf_pkg::ST_RD:     state_d = pgf_pkg::ST_WR;
			pgf_pkg::ST_WR: begin
				state_d = stat.scan_end ? pgf_pkg::ST_SWEEP : pgf_pkg::ST_IDLE;
			end
			pgf_pkg::ST_SWEEP:  if (stat.sweep_done) state_d = pgf_pkg::ST_DILATE;
			pgf_pkg::ST_DILATE: state_d = pgf_pkg::ST_WALK;
			pgf_pkg::ST_WALK:   if (stat.walk_done) state_d = pgf_pkg::ST_EMPTY;
			pgf_pkg::ST_EMPTY:  if (stat.empty_done) state_d = pgf_pkg::ST_CLEAR;
			pgf_pkg::ST_CLEAR:  state_d = pgf_pkg::ST_IDLE;
			default:            state_d = pgf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pgf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pgf_pkg::ST_MUL:    cmd.mul    = 1'b1;
			pgf_pkg::ST_RCP:    cmd.rcp    = 1'b1;
			pgf_pkg::ST_FIX:    cmd.fix    = 1'b1;
			pgf_pkg::ST_RD:     cmd.rd     = 1'b1;
			pgf_pkg::ST_WR:     cmd.wr     = 1'b1;
			pgf_pkg::ST_SWEEP:  cmd.sweep  = 1'b1;
			pgf_pkg::ST_DILATE: cmd.dilate = 1'b1;
			pgf_pkg::ST_WALK:   cmd.walk   = 1'b1;
			pgf_pkg::ST_EMPTY:  cmd.empty  = 1'b1;
			pgf_pkg::ST_CLEAR:  cmd.clear  = 1'b1;
			default:            cmd        = '0;
		endcase
	end

endmodule

// ===== design/pgf_dpath.sv =====
module pgf_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pgf_pkg::cmd_t                        cmd,
	output pgf_pkg::stat_t                       stat,
	input  logic signed [pgf_pkg::ANG_W-1:0]     in_angle,
	input  logic        [pgf_pkg::DIST_W-1:0]    in_dist,
	input  logic                                 in_end,
	input  logic                                 cfg_wen,
	input  logic        [pgf_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic        [pgf_pkg::CFG_DW-1:0]    cfg_wdata,
	pgf_gap_if.source                            gaps
);

	localparam int S     = pgf_pkg::SECTORS;
	localparam int SW    = pgf_pkg::SEC_W;
	localparam int CW    = pgf_pkg::CNT_W;
	localparam int RW    = pgf_pkg::RES_W;
	localparam int PW    = pgf_pkg::PROD_W;
	localparam int MW    = pgf_pkg::PROD_W + pgf_pkg::RCP_W;
	localparam int WRP_W = pgf_pkg::ANG_W + 1;
	localparam logic signed [WRP_W-1:0] HALF_S = WRP_W'(pgf_pkg::HALF_TURN);
	localparam logic signed [WRP_W-1:0] FULL_S = WRP_W'(pgf_pkg::FULL_TURN);

	// circular dilation, up to seven sectors each side
	function automatic logic [S-1:0] dilate(input logic [S-1:0] r,
		input logic [pgf_pkg::MASK_W-1:0] w);
		logic [S-1:0] d;
		d = r;
		for (int k = 1; k < 8; k++) begin
			if (pgf_pkg::MASK_W'(k) <= w) begin
				d = d | (r << k) | (r >> (S - k)) | (r >> k) | (r << (S - k));
			end
		end
		return d;
	endfunction

	// configuration
	logic [15:0]                  max_q, lvl_q;
	logic [pgf_pkg::MASK_W-1:0]   mw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 16'd1500;
			lvl_q <= 16'd525;
			mw_q  <= pgf_pkg::MASK_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				pgf_pkg::REG_MAX_RANGE: max_q <= cfg_wdata;
				pgf_pkg::REG_BLK_LEVEL: lvl_q <= cfg_wdata;
				pgf_pkg::REG_MASK_WID:  mw_q  <= cfg_wdata[pgf_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// point binning
	logic signed [pgf_pkg::ANG_W-1:0]  ang_q;
	logic        [pgf_pkg::DIST_W-1:0] dist_q;
	logic                              end_q;
	logic        [15:0]                mag_q;
	logic                              ok_q;
	logic        [PW-1:0]              prod_q;
	logic        [CW-1:0]              qe_q;
	logic        [SW-1:0]              idx_q;

	logic signed [WRP_W-1:0]           ang_x, ang_w;
	logic        [pgf_pkg::POS_W-1:0]  pos;
	logic        [MW-1:0]              rp;
	logic        [PW-1:0]              rem;
	logic        [CW-1:0]              q_fix;

	always_comb begin
		ang_x = {ang_q[pgf_pkg::ANG_W-1], ang_q};
		if (ang_x < -HALF_S) begin
			ang_w = ang_x + FULL_S;
		end else if (ang_x >= HALF_S) begin
			ang_w = ang_x - FULL_S;
		end else begin
			ang_w = ang_x;
		end
		pos   = pgf_pkg::POS_W'(ang_w + HALF_S);
		rp    = MW'(prod_q) * MW'(pgf_pkg::RCP);
		rem   = prod_q - PW'(qe_q * pgf_pkg::FULL_TURN);
		q_fix = (rem >= PW'(pgf_pkg::FULL_TURN)) ? qe_q + CW'(1) : qe_q;
		if (q_fix >= CW'(S)) q_fix = CW'(S - 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ang_q  <= in_angle;
			dist_q <= in_dist;
			end_q  <= in_end;
		end
		if (cmd.mul) begin
			prod_q <= PW'(pos * S);
			mag_q  <= max_q - dist_q;
			ok_q   <= (dist_q != '0) && (dist_q <= max_q);
		end
		if (cmd.rcp) qe_q  <= CW'(rp >> pgf_pkg::RCP_SH);
		if (cmd.fix) idx_q <= q_fix[SW-1:0];
	end

	// sector peak store; valid bits make an unwritten entry read as zero
	logic [15:0]   peak_mem [S];
	logic [15:0]   rd_data_q;
	logic          vld_rd_q;
	logic [S-1:0]  vld_q;
	logic [CW-1:0] sw_q;
	logic [SW-1:0] rd_addr;
	logic          rd_en, wr_en;
	logic [15:0]   peak_old;

	assign rd_addr  = cmd.sweep ? sw_q[SW-1:0] : idx_q;
	assign rd_en    = cmd.rd || (cmd.sweep && (sw_q < CW'(S)));
	assign peak_old = vld_rd_q ? rd_data_q : 16'd0;
	assign wr_en    = cmd.wr && ok_q && (mag_q > peak_old);

	always_ff @(posedge clk) begin
		if (wr_en) peak_mem[idx_q] <= mag_q;
		if (rd_en) rd_data_q <= peak_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (rd_en) vld_rd_q <= vld_q[rd_addr];
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// sweep: threshold each sector, shift into the raw map
	logic [S-1:0] raw_q, dil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
		end else if (cmd.load) begin
			sw_q <= '0;
		end else if (cmd.sweep) begin
			sw_q <= sw_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep && (sw_q != '0)) begin
			raw_q <= {vld_rd_q && (rd_data_q > lvl_q), raw_q[S-1:1]};
		end
		if (cmd.dilate) dil_q <= dilate(raw_q, mw_q);
	end

	// linear walk for free runs
	logic [SW-1:0] pos_q, beg_q;
	logic          open_q;
	logic [RW-1:0] cnt_q;

	logic          blk, open_now, last_pos, run_end, need, stall, step, more, slot_free;
	logic [SW-1:0] beg_now, last_sec;
	logic [SW:0]   mid_sum;
	logic [S-1:0]  above;
	logic          emit_run, emit_none;

	always_comb begin
		slot_free = !gaps.valid || gaps.ready;
		blk       = dil_q[pos_q];
		open_now  = open_q || !blk;
		beg_now   = open_q ? beg_q : pos_q;
		last_pos  = pos_q == SW'(S - 1);
		run_end   = open_now && (blk || last_pos);
		last_sec  = blk ? pos_q - SW'(1) : pos_q;
		need      = run_end && (cnt_q < RW'(pgf_pkg::MAX_RESULTS));
		stall     = need && !slot_free;
		step      = cmd.walk && !stall;
		above     = {S{1'b1}} << (pos_q + 1);
		more      = |(~dil_q & above);
		mid_sum   = ({1'b0, beg_now} + {1'b0, last_sec}) >> 1;
		emit_run  = step && need;
		emit_none = cmd.empty && (cnt_q == '0) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			beg_q  <= '0;
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.dilate) begin
			pos_q  <= '0;
			beg_q  <= '0;
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (step) begin
			pos_q  <= pos_q + SW'(1);
			beg_q  <= beg_now;
			open_q <= open_now && !run_end;
			if (need) cnt_q <= cnt_q + RW'(1);
		end
	end

	// output register
	logic                             out_vld_q;
	logic signed [pgf_pkg::DIR_W-1:0] dir_q;
	logic [pgf_pkg::GAP_W-1:0]        first_q, final_q;
	logic [S-1:0]                     map_q;
	logic                             has_q, fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_run || emit_none) begin
			out_vld_q <= 1'b1;
		end else if (gaps.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_run) begin
			dir_q   <= pgf_pkg::CENTRE[mid_sum[SW-1:0]];
			first_q <= pgf_pkg::GAP_W'(beg_now);
			final_q <= pgf_pkg::GAP_W'(last_sec);
			map_q   <= dil_q;
			has_q   <= 1'b1;
			fin_q   <= !more || (cnt_q == RW'(pgf_pkg::MAX_RESULTS - 1));
		end else if (emit_none) begin
			dir_q   <= '0;
			first_q <= '0;
			final_q <= '0;
			map_q   <= dil_q;
			has_q   <= 1'b0;
			fin_q   <= 1'b1;
		end
	end

	assign gaps.valid       = out_vld_q;
	assign gaps.direction_q = dir_q;
	assign gaps.gap_first   = first_q;
	assign gaps.gap_final   = final_q;
	assign gaps.blocked_map = map_q;
	assign gaps.has_gap     = has_q;
	assign gaps.final_gap   = fin_q;

	assign stat.scan_end   = end_q;
	assign stat.sweep_done = sw_q == CW'(S);
	assign stat.walk_done  = last_pos && !stall;
	assign stat.empty_done = (cnt_q != '0) || slot_free;

endmodule

// ===== design/polar_obstacle_gap_finder.sv =====
// Polar obstacle gap finder.
// points: one lidar point per beat (angle_q in 1/16 deg, distance_mm, scan_end).
// gaps:   one free run of sectors per beat, walked from sector 0 upward; a scan
//         with no free sector gives a single beat with has_gap low. final_gap
//         marks the last beat of a scan.
// cfg:    write port (cfg_wen, cfg_addr, cfg_wdata); write only while idle.
// Steps:  a point passes through wrap and multiply, reciprocal divide,
//         correction, store read and store write-back before the next ready.
//         On scan_end follow the store sweep, dilation, the walk (held by any
//         output stall) and the empty check and clear that close the scan;
//         the first gap beat shows in the cycle after the walk reaches the end
//         of that run.
// Reset:  store valid bits cleared at once (no clearing pass), registers back
//         to 1500 / 525 / 1, no result pending.
// Stall:  a result waits in the output register; the walk stops at the next
//         run end until that beat is taken. Points are taken only while idle.
module polar_obstacle_gap_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	pgf_pt_if.sink                            points,
	pgf_gap_if.source                         gaps,
	input  logic                              cfg_wen,
	input  logic [pgf_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [pgf_pkg::CFG_DW-1:0]        cfg_wdata
);

	pgf_pkg::cmd_t  cmd;
	pgf_pkg::stat_t stat;
	logic           in_ready;

	assign points.ready = in_ready;

	// sequencer: binning steps, sweep, dilation, walk, close-out
	pgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: sector store, threshold map, run finder, output register
	pgf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_angle  (points.angle_q),
		.in_dist   (points.distance_mm),
		.in_end    (points.scan_end),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.gaps      (gaps)
	);

endmodule

// ===== design/pgf_checker.sv =====
module pgf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pgf_pkg::GAP_W-1:0]     gap_first,
	input logic [pgf_pkg::GAP_W-1:0]     gap_final,
	input logic [pgf_pkg::SECTORS-1:0]   blocked_map,
	input logic                          has_gap,
	input logic                          final_gap
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_none_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_gap |-> final_gap)
		else $error("no-gap beat not final");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_gap |-> gap_first <= gap_final)
		else $error("gap ends before it starts");

	a_free_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_gap |-> !blocked_map[gap_first] && !blocked_map[gap_final])
		else $error("gap edge sector is blocked");

endmodule

bind polar_obstacle_gap_finder pgf_checker u_pgf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (gaps.valid),
	.out_ready   (gaps.ready),
	.gap_first   (gaps.gap_first),
	.gap_final   (gaps.gap_final),
	.blocked_map (gaps.blocked_map),
	.has_gap     (gaps.has_gap),
	.final_gap   (gaps.final_gap)
);
